FILE: hw/rtl/cts_pkg.sv
// Package for the task table scheduler: widths, table size, opcode, slot state,
// status and sequencer state codes, and the round-robin slot increment.
// No dependencies.
package cts_pkg;

	// Table size and derived widths
	localparam int SLOTS  = 8;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	// Field widths of the transaction payloads
	localparam int OPCODE_W = 3;
	localparam int EVENT_W  = 32;
	localparam int PID_W    = 32;
	localparam int STATUS_W = 3;
	localparam int SLOTF_W  = 3;
	localparam int WOKEN_W  = 4;
	localparam int WOKEN_MAX = (2 ** WOKEN_W) - 1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CREATE = 3'd0,
		OP_YIELD  = 3'd1,
		OP_SLEEP  = 3'd2,
		OP_WAKE   = 3'd3,
		OP_EXIT   = 3'd4,
		OP_KILL   = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		SS_UNUSED  = 3'd0,
		SS_READY   = 3'd1,
		SS_RUNNING = 3'd2,
		SS_BLOCKED = 3'd3,
		SS_ZOMBIE  = 3'd4
	} slot_state_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK             = 3'd0,
		STS_NO_FREE_SLOT   = 3'd1,
		STS_PID_NOT_FOUND  = 3'd2,
		STS_TARGET_RUNNING = 3'd3,
		STS_NO_CURRENT     = 3'd4,
		STS_KEEP_RUNNING   = 3'd5,
		STS_WAIT_EVENT     = 3'd6,
		STS_NOTHING_ALIVE  = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_CREATE,
		SEQ_YIELD,
		SEQ_DEMOTE,
		SEQ_CURCHK,
		SEQ_WAKE,
		SEQ_KILL,
		SEQ_FIN
	} seq_state_t;

	// Next slot in round-robin order, wrapping after the last slot
	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/cts_req_if.sv
// Request channel of the task table scheduler: valid/ready plus the operation.
// Depends on cts_pkg for field widths.
interface cts_req_if;
	logic                          valid;
	logic                          ready;
	logic [cts_pkg::OPCODE_W-1:0]  opcode;
	logic [cts_pkg::EVENT_W-1:0]   evt_num;
	logic [cts_pkg::PID_W-1:0]     target_pid;

	modport source (output valid, output opcode, output evt_num, output target_pid,
		input ready);
	modport sink (input valid, input opcode, input evt_num, input target_pid,
		output ready);
endinterface

FILE: hw/rtl/cts_rsp_if.sv
// Response channel of the task table scheduler: valid/ready plus the result.
// Depends on cts_pkg for field widths.
interface cts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cts_pkg::STATUS_W-1:0]  status;
	logic [cts_pkg::PID_W-1:0]     result_pid;
	logic [cts_pkg::SLOTF_W-1:0]   result_slot;
	logic [cts_pkg::SLOTF_W-1:0]   current_slot;
	logic                          current_valid;
	logic [cts_pkg::WOKEN_W-1:0]   woken_count;

	modport source (output valid, output status, output result_pid, output result_slot,
		output current_slot, output current_valid, output woken_count, input ready);
	modport sink (input valid, input status, input result_pid, input result_slot,
		input current_slot, input current_valid, input woken_count, output ready);
endinterface

FILE: hw/rtl/cooperative_task_table_scheduler.sv
// Cooperative task table scheduler: task slot table, round-robin yield, event wait.
// Depends on cts_pkg, cts_req_if and cts_rsp_if.
//
// One request transaction is taken at a time; req.ready is high only while the
// sequencer is idle. The table is walked one slot per cycle through a single
// read port with a 32-bit pid compare and a 32-bit event compare. An unknown
// opcode, or sleep/exit without a current task, goes straight to the response;
// create, wake and kill scan the table, and yield, sleep and exit scan it and
// may then demote the old task or check the current one. The response sits in
// an output register; a new request is accepted while it waits, and that
// request's response is held back until the old one is taken.
// Pid and wait-event entries of slots that were never written hold no defined
// value; they are only consulted for slots in use.
module cooperative_task_table_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	cts_req_if.sink       req,
	cts_rsp_if.source     rsp
);

	localparam logic [cts_pkg::SLOT_W-1:0] LAST_SLOT = cts_pkg::SLOT_W'(cts_pkg::SLOTS - 1);

	// Sequencer state
	cts_pkg::seq_state_t state_q, state_d;

	// Task table
	cts_pkg::slot_state_t          slot_state_q [cts_pkg::SLOTS];
	logic [cts_pkg::SLOTS-1:0]     wait_valid_q;
	logic [cts_pkg::PID_W-1:0]     pid_mem   [cts_pkg::SLOTS];
	logic [cts_pkg::EVENT_W-1:0]   event_mem [cts_pkg::SLOTS];

	// Scheduler registers
	logic [cts_pkg::PID_W-1:0]     next_pid_q;
	logic [cts_pkg::SLOT_W-1:0]    cur_q;
	logic                          cur_valid_q;

	// Scan unit
	logic [cts_pkg::SLOT_W-1:0]    idx_q;
	logic [cts_pkg::SLOT_W-1:0]    step_q;
	logic                          blocked_q;
	logic [cts_pkg::EVENT_W-1:0]   ev_q;
	logic [cts_pkg::PID_W-1:0]     tpid_q;

	// Result of the running transaction
	cts_pkg::status_t              res_status_q;
	logic [cts_pkg::PID_W-1:0]     res_pid_q;
	logic [cts_pkg::SLOT_W-1:0]    res_slot_q;
	logic [cts_pkg::CNT_W-1:0]     woken_q;

	// Output register
	logic                          out_valid_q;
	cts_pkg::status_t              out_status_q;
	logic [cts_pkg::PID_W-1:0]     out_pid_q;
	logic [cts_pkg::SLOTF_W-1:0]   out_slot_q;
	logic [cts_pkg::SLOTF_W-1:0]   out_cur_q;
	logic                          out_cur_valid_q;
	logic [cts_pkg::WOKEN_W-1:0]   out_woken_q;

	// Read port at the scan index and the shared compares
	cts_pkg::slot_state_t          st_rd;
	logic [cts_pkg::PID_W-1:0]     pid_rd;
	logic [cts_pkg::EVENT_W-1:0]   ev_rd;
	logic                          wv_rd;
	logic                          last_step;
	logic                          accept;
	logic                          out_free;
	logic                          hit_create;
	logic                          hit_ready;
	logic                          hit_wake;
	logic                          hit_kill;
	logic                          mark_cur;
	cts_pkg::opcode_t              op_in;
	logic [cts_pkg::SLOT_W-1:0]    start_slot;

	assign st_rd     = slot_state_q[idx_q];
	assign pid_rd    = pid_mem[idx_q];
	assign ev_rd     = event_mem[idx_q];
	assign wv_rd     = wait_valid_q[idx_q];
	assign last_step = (step_q == LAST_SLOT);
	assign op_in     = cts_pkg::opcode_t'(req.opcode);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign start_slot = cur_valid_q ? cur_q : LAST_SLOT;

	assign hit_create = (st_rd == cts_pkg::SS_UNUSED);
	assign hit_ready  = (st_rd == cts_pkg::SS_READY);
	assign hit_wake   = (st_rd == cts_pkg::SS_BLOCKED) && wv_rd && (ev_rd == ev_q);
	assign hit_kill   = (st_rd != cts_pkg::SS_UNUSED) && (pid_rd == tpid_q);
	assign mark_cur   = accept && cur_valid_q &&
		((op_in == cts_pkg::OP_SLEEP) || (op_in == cts_pkg::OP_EXIT));

	// Next state and handshake
	always_comb begin
		state_d   = state_q;
		req.ready = (state_q == cts_pkg::SEQ_IDLE);
		unique case (state_q)
			cts_pkg::SEQ_IDLE: begin
				if (req.valid) begin
					unique case (op_in)
						cts_pkg::OP_CREATE: state_d = cts_pkg::SEQ_CREATE;
						cts_pkg::OP_YIELD:  state_d = cts_pkg::SEQ_YIELD;
						cts_pkg::OP_SLEEP,
						cts_pkg::OP_EXIT:   state_d = cur_valid_q ? cts_pkg::SEQ_YIELD
							: cts_pkg::SEQ_FIN;
						cts_pkg::OP_WAKE:   state_d = cts_pkg::SEQ_WAKE;
						cts_pkg::OP_KILL:   state_d = cts_pkg::SEQ_KILL;
						default:            state_d = cts_pkg::SEQ_FIN;
					endcase
				end
			end
			cts_pkg::SEQ_CREATE: begin
				if (hit_create || last_step) state_d = cts_pkg::SEQ_FIN;
			end
			cts_pkg::SEQ_YIELD: begin
				if (hit_ready) begin
					state_d = (cur_valid_q && (cur_q != idx_q)) ? cts_pkg::SEQ_DEMOTE
						: cts_pkg::SEQ_FIN;
				end else if (last_step) begin
					state_d = cts_pkg::SEQ_CURCHK;
				end
			end
			cts_pkg::SEQ_DEMOTE: state_d = cts_pkg::SEQ_FIN;
			cts_pkg::SEQ_CURCHK: state_d = cts_pkg::SEQ_FIN;
			cts_pkg::SEQ_WAKE: begin
				if (last_step) state_d = cts_pkg::SEQ_FIN;
			end
			cts_pkg::SEQ_KILL: begin
				if (hit_kill || last_step) state_d = cts_pkg::SEQ_FIN;
			end
			cts_pkg::SEQ_FIN: begin
				if (out_free) state_d = cts_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cts_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pid and wait-event storage, no reset
	always_ff @(posedge clk) begin
		if ((state_q == cts_pkg::SEQ_CREATE) && hit_create) begin
			pid_mem[idx_q] <= next_pid_q;
		end
		if (mark_cur && (op_in == cts_pkg::OP_SLEEP)) begin
			event_mem[cur_q] <= req.evt_num;
		end
	end

	// Table state, scheduler registers and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cts_pkg::SLOTS; i++) begin
				slot_state_q[i] <= cts_pkg::SS_UNUSED;
			end
			wait_valid_q <= '0;
			next_pid_q   <= cts_pkg::PID_W'(1);
			cur_q        <= '0;
			cur_valid_q  <= 1'b0;
			idx_q        <= '0;
			step_q       <= '0;
			blocked_q    <= 1'b0;
		end else begin
			unique case (state_q)
				cts_pkg::SEQ_IDLE: begin
					step_q    <= '0;
					blocked_q <= 1'b0;
					if (accept) begin
						// sleep and exit mark the current slot before the yield scan
						if (mark_cur) begin
							if (op_in == cts_pkg::OP_SLEEP) begin
								slot_state_q[cur_q] <= cts_pkg::SS_BLOCKED;
								wait_valid_q[cur_q] <= 1'b1;
							end else begin
								slot_state_q[cur_q] <= cts_pkg::SS_ZOMBIE;
							end
						end
						if ((op_in == cts_pkg::OP_YIELD) || mark_cur) begin
							idx_q <= cts_pkg::slot_next(start_slot);
						end else begin
							idx_q <= '0;
						end
					end
				end
				cts_pkg::SEQ_CREATE: begin
					if (hit_create) begin
						slot_state_q[idx_q] <= cts_pkg::SS_READY;
						wait_valid_q[idx_q] <= 1'b0;
						next_pid_q          <= next_pid_q + 1'b1;
					end else begin
						idx_q  <= cts_pkg::slot_next(idx_q);
						step_q <= step_q + 1'b1;
					end
				end
				cts_pkg::SEQ_YIELD: begin
					if (hit_ready) begin
						// switch, then point the scan at the old slot for demotion
						slot_state_q[idx_q] <= cts_pkg::SS_RUNNING;
						cur_q       <= idx_q;
						cur_valid_q <= 1'b1;
						idx_q       <= cur_q;
					end else if (last_step) begin
						blocked_q <= blocked_q || (st_rd == cts_pkg::SS_BLOCKED);
						idx_q     <= cur_q;
					end else begin
						blocked_q <= blocked_q || (st_rd == cts_pkg::SS_BLOCKED);
						idx_q     <= cts_pkg::slot_next(idx_q);
						step_q    <= step_q + 1'b1;
					end
				end
				cts_pkg::SEQ_DEMOTE: begin
					if (st_rd == cts_pkg::SS_RUNNING) begin
						slot_state_q[idx_q] <= cts_pkg::SS_READY;
					end
				end
				cts_pkg::SEQ_CURCHK: begin
				end
				cts_pkg::SEQ_WAKE: begin
					if (hit_wake) begin
						slot_state_q[idx_q] <= cts_pkg::SS_READY;
						wait_valid_q[idx_q] <= 1'b0;
					end
					idx_q  <= cts_pkg::slot_next(idx_q);
					step_q <= step_q + 1'b1;
				end
				cts_pkg::SEQ_KILL: begin
					if (hit_kill) begin
						if (st_rd != cts_pkg::SS_RUNNING) begin
							slot_state_q[idx_q] <= cts_pkg::SS_UNUSED;
							wait_valid_q[idx_q] <= 1'b0;
						end
					end else begin
						idx_q  <= cts_pkg::slot_next(idx_q);
						step_q <= step_q + 1'b1;
					end
				end
				cts_pkg::SEQ_FIN: begin
				end
			endcase
		end
	end

	// Result of the running transaction
	always_ff @(posedge clk) begin
		unique case (state_q)
			cts_pkg::SEQ_IDLE: begin
				if (accept) begin
					ev_q         <= req.evt_num;
					tpid_q       <= req.target_pid;
					res_pid_q    <= '0;
					res_slot_q   <= '0;
					woken_q      <= '0;
					if (((op_in == cts_pkg::OP_SLEEP) || (op_in == cts_pkg::OP_EXIT)) &&
							!cur_valid_q) begin
						res_status_q <= cts_pkg::STS_NO_CURRENT;
					end else begin
						res_status_q <= cts_pkg::STS_OK;
					end
				end
			end
			cts_pkg::SEQ_CREATE: begin
				if (hit_create) begin
					res_status_q <= cts_pkg::STS_OK;
					res_pid_q    <= next_pid_q;
					res_slot_q   <= idx_q;
				end else if (last_step) begin
					res_status_q <= cts_pkg::STS_NO_FREE_SLOT;
				end
			end
			cts_pkg::SEQ_YIELD: begin
				if (hit_ready) begin
					res_status_q <= cts_pkg::STS_OK;
					res_pid_q    <= pid_rd;
					res_slot_q   <= idx_q;
				end
			end
			cts_pkg::SEQ_DEMOTE: begin
			end
			cts_pkg::SEQ_CURCHK: begin
				// no ready slot: keep the running task, else report waiting or empty
				if (cur_valid_q && (st_rd == cts_pkg::SS_RUNNING)) begin
					res_status_q <= cts_pkg::STS_KEEP_RUNNING;
					res_pid_q    <= pid_rd;
					res_slot_q   <= idx_q;
				end else if (blocked_q) begin
					res_status_q <= cts_pkg::STS_WAIT_EVENT;
				end else begin
					res_status_q <= cts_pkg::STS_NOTHING_ALIVE;
				end
			end
			cts_pkg::SEQ_WAKE: begin
				if (hit_wake) begin
					woken_q <= woken_q + 1'b1;
				end
			end
			cts_pkg::SEQ_KILL: begin
				if (hit_kill) begin
					res_status_q <= (st_rd == cts_pkg::SS_RUNNING) ?
						cts_pkg::STS_TARGET_RUNNING : cts_pkg::STS_OK;
				end else if (last_step) begin
					res_status_q <= cts_pkg::STS_PID_NOT_FOUND;
				end
			end
			cts_pkg::SEQ_FIN: begin
			end
		endcase
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == cts_pkg::SEQ_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if ((state_q == cts_pkg::SEQ_FIN) && out_free) begin
			out_status_q    <= res_status_q;
			out_pid_q       <= res_pid_q;
			out_slot_q      <= cts_pkg::SLOTF_W'(res_slot_q);
			out_cur_q       <= cts_pkg::SLOTF_W'(cur_q);
			out_cur_valid_q <= cur_valid_q;
			if (32'(woken_q) > 32'(cts_pkg::WOKEN_MAX)) begin
				out_woken_q <= cts_pkg::WOKEN_W'(cts_pkg::WOKEN_MAX);
			end else begin
				out_woken_q <= cts_pkg::WOKEN_W'(woken_q);
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.result_pid    = out_pid_q;
	assign rsp.result_slot   = out_slot_q;
	assign rsp.current_slot  = out_cur_q;
	assign rsp.current_valid = out_cur_valid_q;
	assign rsp.woken_count   = out_woken_q;

endmodule

FILE: hw/rtl/cts_checker.sv
// Port-level checker for the task table scheduler, bound to the top level.
// Depends on cts_pkg for status codes and field widths.
module cts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [cts_pkg::STATUS_W-1:0]  rsp_status,
	input logic [cts_pkg::PID_W-1:0]     rsp_result_pid,
	input logic [cts_pkg::SLOTF_W-1:0]   rsp_result_slot,
	input logic [cts_pkg::SLOTF_W-1:0]   rsp_current_slot,
	input logic                          rsp_current_valid,
	input logic [cts_pkg::WOKEN_W-1:0]   rsp_woken_count
);

	// A stalled response keeps its status, result pid and woken count
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_result_pid) && $stable(rsp_woken_count))
		else $error("stalled response changed");

	// The sequencer is busy right after taking a request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// Keeping the running task names the current slot
	a_keep_is_current: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == cts_pkg::STS_KEEP_RUNNING) |->
			rsp_current_valid && (rsp_result_slot == rsp_current_slot))
		else $error("keep-running response does not match current slot");

	// No current task reported only when none exists
	a_no_current: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == cts_pkg::STS_NO_CURRENT) |-> !rsp_current_valid)
		else $error("no-current status with a current task");

	// Woken tasks come only with a success status, and the slot is zero with no task
	a_woken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_woken_count != '0) |-> (rsp_status == cts_pkg::STS_OK) &&
			(rsp_current_valid || (rsp_current_slot == '0)))
		else $error("wake count with bad status or stray current slot");

endmodule

bind cooperative_task_table_scheduler cts_checker u_cts_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_result_pid    (rsp.result_pid),
	.rsp_result_slot   (rsp.result_slot),
	.rsp_current_slot  (rsp.current_slot),
	.rsp_current_valid (rsp.current_valid),
	.rsp_woken_count   (rsp.woken_count)
);
